// File: hdl/alu8f_pkg.sv
// alu8f_pkg: operation codes, flag and result types and constants of the 8-bit alu
// no dependencies; compiled first
`default_nettype none

package alu8f_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBC = 4'd3,
		OP_AND = 4'd4,
		OP_XOR = 4'd5,
		OP_OR  = 4'd6,
		OP_CP  = 4'd7,
		OP_INC = 4'd8,
		OP_DEC = 4'd9,
		OP_DAA = 4'd10,
		OP_CPL = 4'd11,
		OP_SCF = 4'd12,
		OP_CCF = 4'd13
	} alu_op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [7:0] result;
		logic       write_back;
		flags_t     flags;
	} alu_res_t;

	localparam flags_t FLAGS_RESET = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

	localparam logic [7:0] DAA_LIMIT   = 8'h99;
	localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
	localparam logic [3:0] DAA_NIB_MAX = 4'd9;
	localparam logic [3:0] NIB_ALL     = 4'hF;

endpackage

`default_nettype wire

// File: hdl/alu8f_if.sv
// alu8f_req_if / alu8f_rsp_if: valid-ready channels of the alu
// depends on nothing; fields follow the request and response item layouts
`default_nettype none

interface alu8f_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] dest_value;
	logic [7:0] source_value;

	modport source (output valid, output mode, output dest_value, output source_value,
		input ready);
	modport sink (input valid, input mode, input dest_value, input source_value,
		output ready);
	modport mon (input valid, input ready, input mode, input dest_value,
		input source_value);
endinterface

interface alu8f_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       write_back;
	logic       zero_flag;
	logic       subtract_flag;
	logic       half_carry_flag;
	logic       carry_flag;

	modport source (output valid, output result, output write_back, output zero_flag,
		output subtract_flag, output half_carry_flag, output carry_flag, input ready);
	modport sink (input valid, input result, input write_back, input zero_flag,
		input subtract_flag, input half_carry_flag, input carry_flag, output ready);
	modport mon (input valid, input ready, input result, input write_back,
		input zero_flag, input subtract_flag, input half_carry_flag, input carry_flag);
endinterface

`default_nettype wire

// File: hdl/alu8f_core.sv
// alu8f_core: combinational operation logic, result value, write-back mark and new flags
// depends on alu8f_pkg
`default_nettype none

module alu8f_core (
	input  logic [3:0]         mode,
	input  logic [7:0]         dest_value,
	input  logic [7:0]         source_value,
	input  alu8f_pkg::flags_t  flags_in,
	output alu8f_pkg::alu_res_t res
);
	import alu8f_pkg::*;

	alu_op_t    op;
	logic       cin;
	logic [8:0] sum9;
	logic [4:0] hsum5;
	logic [8:0] diff9;
	logic [4:0] hdiff5;
	logic [7:0] inc8;
	logic [7:0] dec8;
	logic       daa_hi;
	logic [7:0] daa_mid;
	logic       daa_lo;
	logic [7:0] daa_add;
	logic [7:0] daa_hsub;
	logic [7:0] daa_sub;
	logic [7:0] daa_r;
	logic       daa_c;
	logic [7:0] r;

	assign op  = alu_op_t'(mode);
	assign cin = ((op == OP_ADC) || (op == OP_SBC)) && flags_in.c;

	assign sum9   = {1'b0, dest_value} + {1'b0, source_value} + {8'd0, cin};
	assign hsum5  = {1'b0, dest_value[3:0]} + {1'b0, source_value[3:0]} + {4'd0, cin};
	assign diff9  = {1'b0, dest_value} - {1'b0, source_value} - {8'd0, cin};
	assign hdiff5 = {1'b0, dest_value[3:0]} - {1'b0, source_value[3:0]} - {4'd0, cin};
	assign inc8   = dest_value + 8'd1;
	assign dec8   = dest_value - 8'd1;

	// decimal adjust, add and subtract forms
	assign daa_hi   = flags_in.c || (dest_value > DAA_LIMIT);
	assign daa_mid  = daa_hi ? dest_value + DAA_HI_ADJ : dest_value;
	assign daa_lo   = flags_in.h || (daa_mid[3:0] > DAA_NIB_MAX);
	assign daa_add  = daa_lo ? daa_mid + DAA_LO_ADJ : daa_mid;
	assign daa_hsub = flags_in.c ? dest_value - DAA_HI_ADJ : dest_value;
	assign daa_sub  = flags_in.h ? daa_hsub - DAA_LO_ADJ : daa_hsub;
	assign daa_r    = flags_in.n ? daa_sub : daa_add;
	assign daa_c    = flags_in.c || (!flags_in.n && daa_hi);

	always_comb begin
		r              = dest_value;
		res.write_back = 1'b1;
		res.flags      = flags_in;
		unique case (op)
			OP_ADD, OP_ADC: begin
				r         = sum9[7:0];
				res.flags = '{z: (r == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			OP_SUB, OP_SBC: begin
				r         = diff9[7:0];
				res.flags = '{z: (r == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			OP_CP: begin
				res.write_back = 1'b0;
				res.flags = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			OP_AND: begin
				r         = dest_value & source_value;
				res.flags = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			OP_XOR: begin
				r         = dest_value ^ source_value;
				res.flags = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_OR: begin
				r         = dest_value | source_value;
				res.flags = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_INC: begin
				r         = inc8;
				res.flags = '{z: (r == 8'd0), n: 1'b0, h: (r[3:0] == 4'd0), c: flags_in.c};
			end
			OP_DEC: begin
				r         = dec8;
				res.flags = '{z: (r == 8'd0), n: 1'b1, h: (r[3:0] == NIB_ALL), c: flags_in.c};
			end
			OP_DAA: begin
				r         = daa_r;
				res.flags = '{z: (r == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
			end
			OP_CPL: begin
				r         = ~dest_value;
				res.flags = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
			end
			OP_SCF: begin
				res.write_back = 1'b0;
				res.flags      = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			OP_CCF: begin
				res.write_back = 1'b0;
				res.flags      = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: !flags_in.c};
			end
			default: begin
				res.write_back = 1'b0;
			end
		endcase
		res.result = r;
	end

endmodule

`default_nettype wire

// File: hdl/cpu_8bit_alu_with_flags_top.sv
// cpu_8bit_alu_with_flags_top: 8-bit alu with kept z/n/h/c flags, two register stages
// depends on alu8f_pkg, alu8f_req_if, alu8f_rsp_if, alu8f_core
//
// usage:
//  req channel carries mode, dest_value and source_value; rsp channel returns
//  result, write_back and the four new flags, one response for every request
//  a request accepted on req is latched into the input stage, runs through the
//  operation logic and is registered into the result register, which drives rsp
//  until the response is taken; throughput is one request per cycle while rsp
//  is not stalled; the kept flags are updated as a request leaves the input stage,
//  so the following request sees them with no bubble
//  adc, sbc, inc, dec, daa, cpl, scf and ccf read the flags left by the
//  previous request
//  an output register separates the channels: req.ready stays high while the
//  result register is free or being taken; with rsp stalled one request is
//  held in the input stage and one in the result register, then req.ready drops
//  reset clears both stage valids and the flags (all zero)
`default_nettype none

module cpu_8bit_alu_with_flags_top (
	input  logic clk,
	input  logic arst_n,
	alu8f_req_if.sink   req,
	alu8f_rsp_if.source rsp
);
	import alu8f_pkg::*;

	logic       valid_s1;
	logic [3:0] mode_s1;
	logic [7:0] dest_s1;
	logic [7:0] src_s1;
	logic       out_valid_q;
	alu_res_t   res_q;
	flags_t     flags_q;
	alu_res_t   core_res;
	logic       adv;
	logic       take;
	logic       fire;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;
	assign fire      = valid_s1 && adv;

	alu8f_core u_core (
		.mode         (mode_s1),
		.dest_value   (dest_s1),
		.source_value (src_s1),
		.flags_in     (flags_q),
		.res          (core_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= FLAGS_RESET;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				flags_q <= core_res.flags;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= req.mode;
			dest_s1 <= req.dest_value;
			src_s1  <= req.source_value;
		end
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.result          = res_q.result;
	assign rsp.write_back      = res_q.write_back;
	assign rsp.zero_flag       = res_q.flags.z;
	assign rsp.subtract_flag   = res_q.flags.n;
	assign rsp.half_carry_flag = res_q.flags.h;
	assign rsp.carry_flag      = res_q.flags.c;

endmodule

`default_nettype wire

// File: hdl/alu8f_checker.sv
// alu8f_checker: port-level checks of the alu channels, bound to the top level
// depends on alu8f_req_if, alu8f_rsp_if, cpu_8bit_alu_with_flags_top
`default_nettype none

module alu8f_checker (
	input logic clk,
	input logic arst_n,
	alu8f_req_if.sink   req,
	alu8f_rsp_if.source rsp
);

	// stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("rsp.valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(rsp.result) && $stable(rsp.write_back)
			&& $stable(rsp.zero_flag) && $stable(rsp.subtract_flag)
			&& $stable(rsp.half_carry_flag) && $stable(rsp.carry_flag))
		else $error("rsp payload changed while stalled");

	// request reaches the output register once the output moves
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) ##1 (!rsp.valid || rsp.ready) |=> rsp.valid)
		else $error("request did not reach rsp");

	// free output never blocks requests
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp.valid || rsp.ready) |-> req.ready)
		else $error("req.ready low while output free");

endmodule

bind cpu_8bit_alu_with_flags_top alu8f_checker u_alu8f_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire
